@@ hw/rtl/assp_pkg.sv @@
// Shared types and constants for the animation script stream parser.
package assp_pkg;

  localparam int HEADER_BYTES = 8;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PARSE,
    PH_TERM,
    PH_PENDING,
    PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    K_HEADER         = 4'd0,
    K_ARG            = 4'd1,
    K_END_OK         = 4'd2,
    K_BAD_TERM_OP    = 4'd3,
    K_BAD_TERM_SIZE  = 4'd4,
    K_HDR_PAST_BOUND = 4'd5,
    K_BAD_SIZE       = 4'd6,
    K_INS_PAST_BOUND = 4'd7,
    K_OP_TOO_HIGH    = 4'd8,
    K_NO_TERM        = 4'd9
  } kind_t;

  localparam logic [1:0] CFG_TERM_OP   = 2'd0;
  localparam logic [1:0] CFG_TERM_SIZE = 2'd1;
  localparam logic [1:0] CFG_MAX_OP    = 2'd2;

endpackage

@@ hw/rtl/anim_script_stream_parser_top.sv @@
// Animation script stream parser: splits a script region into instruction records.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | data_byte, region_start, region_length
//  out_    | output    | out_valid / out_ready | kind, opcode, byte_size, time_value,
//          |           |                       | operand_flags, arg_byte, is_last
//  cfg_    | input     | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// One byte per cycle while in_ready is high: each byte updates the parse state and
// loads at most one record into the output register in the same cycle.
// Sustained rate is set by the single output register: in_ready drops only while a
// record waits and out_ready is low.
// Synchronous active-low reset idles the parser and clears the output valid flag.
// Bytes before the first region start are dropped without a record.
module anim_script_stream_parser_top #(
  parameter int REGION_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_region_start,
  input  logic [23:0]         in_region_length,
  output logic                out_valid,
  input  logic                out_ready,
  output assp_pkg::kind_t     out_kind,
  output logic [14:0]         out_opcode,
  output logic [15:0]         out_byte_size,
  output logic signed [15:0]  out_time_value,
  output logic [15:0]         out_operand_flags,
  output logic [7:0]          out_arg_byte,
  output logic                out_is_last,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import assp_pkg::*;

  localparam int SW = (REGION_BITS > 16 ? REGION_BITS : 16) + 1;
  localparam int LW = (REGION_BITS < 24) ? REGION_BITS : 24;

  logic [15:0] term_op_r, term_size_r;
  logic [14:0] max_op_r;

  phase_t                 phase_r, phase_nxt;
  logic [REGION_BITS-1:0] pos_r, pos_nxt, end_r, end_nxt;
  logic [15:0]            k_r, k_nxt;
  logic [15:0]            hw_r [4];
  logic [15:0]            hw_nxt [4];
  logic [7:0]             hold_r, hold_nxt;

  logic                   out_valid_r;
  kind_t                  kind_r;
  logic [14:0]            opcode_r;
  logic [15:0]            size_out_r, time_r, flags_r;
  logic [7:0]             arg_r;
  logic                   last_r;

  logic                   res_v;
  kind_t                  res_kind;
  logic [14:0]            res_opcode;
  logic [15:0]            res_size, res_time, res_flags;
  logic [7:0]             res_arg;
  logic                   res_last;

  logic                   in_fire;
  logic [REGION_BITS-1:0] len_c;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign len_c    = REGION_BITS'(in_region_length[LW-1:0]);

  always_comb begin
    logic                   pend, tb_v, adv, fin;
    phase_t                 ph_e;
    logic [REGION_BITS-1:0] pos_e, end_e;
    logic [15:0]            k_e, w, size;
    logic [7:0]             hold_e;
    logic [SW-1:0]          start_s, end_s, pos1_s;
    logic [16:0]            k1;
    kind_t                  tb_kind;

    pend    = (phase_r == PH_PENDING);
    ph_e    = pend ? PH_DONE : phase_r;
    pos_e   = pos_r;
    end_e   = end_r;
    k_e     = k_r;
    hold_e  = hold_r;
    if (in_region_start) begin
      ph_e   = PH_PARSE;
      pos_e  = '0;
      end_e  = len_c;
      k_e    = '0;
      hold_e = '0;
    end

    phase_nxt = ph_e;
    pos_nxt   = pos_e;
    end_nxt   = end_e;
    k_nxt     = k_e;
    hold_nxt  = hold_e;
    for (int i = 0; i < 4; i++) hw_nxt[i] = hw_r[i];

    res_v      = pend;
    res_kind   = K_NO_TERM;
    res_opcode = '0;
    res_size   = '0;
    res_time   = '0;
    res_flags  = '0;
    res_arg    = '0;
    res_last   = 1'b0;

    w       = {in_data_byte, hold_e};
    size    = hw_r[1];
    start_s = SW'(pos_e) - SW'(k_e);
    end_s   = SW'(end_e);
    pos1_s  = SW'(pos_e) + SW'(1);
    k1      = {1'b0, k_e} + 17'd1;
    tb_v    = 1'b0;
    tb_kind = K_NO_TERM;
    adv     = 1'b0;
    fin     = 1'b0;

    if (ph_e == PH_TERM) begin
      if (k_e == 16'd2) begin
        hold_nxt = in_data_byte;
        k_nxt    = 16'd3;
        pos_nxt  = REGION_BITS'(pos1_s);
      end else begin
        tb_v      = 1'b1;
        tb_kind   = (w == term_size_r) ? K_END_OK : K_BAD_TERM_SIZE;
        phase_nxt = PH_DONE;
      end
    end else if (ph_e == PH_PARSE) begin
      adv = 1'b1;
      if (k_e == 16'd0) begin
        if (start_s + SW'(2) > end_s) begin
          tb_v      = 1'b1;
          tb_kind   = K_NO_TERM;
          phase_nxt = PH_DONE;
          adv       = 1'b0;
        end else begin
          hold_nxt = in_data_byte;
        end
      end else if (k_e < 16'(HEADER_BYTES)) begin
        if (!k_e[0]) hold_nxt = in_data_byte;
        else hw_nxt[k_e[2:1]] = w;
        if (k_e == 16'd1) begin
          if (w[15]) begin
            if (w != term_op_r) begin
              tb_v      = 1'b1;
              tb_kind   = K_BAD_TERM_OP;
              phase_nxt = PH_DONE;
              adv       = 1'b0;
            end else if (start_s + SW'(4) <= end_s) begin
              phase_nxt = PH_TERM;
            end else begin
              tb_v      = 1'b1;
              tb_kind   = K_END_OK;
              phase_nxt = PH_DONE;
              adv       = 1'b0;
            end
          end else if (start_s + SW'(HEADER_BYTES) > end_s) begin
            tb_v      = 1'b1;
            tb_kind   = K_HDR_PAST_BOUND;
            phase_nxt = PH_DONE;
            adv       = 1'b0;
          end
        end else if (k_e == 16'(HEADER_BYTES - 1)) begin
          tb_v = 1'b1;
          adv  = 1'b0;
          phase_nxt = PH_DONE;
          if (size < 16'(HEADER_BYTES) || size[1:0] != 2'b00) begin
            tb_kind = K_BAD_SIZE;
          end else if (start_s + SW'(size) > end_s) begin
            tb_kind = K_INS_PAST_BOUND;
          end else if (hw_r[0][14:0] > max_op_r) begin
            tb_kind = K_OP_TOO_HIGH;
          end else begin
            tb_kind    = K_HEADER;
            res_opcode = hw_r[0][14:0];
            res_size   = size;
            res_time   = hw_r[2];
            res_flags  = w;
            res_last   = (size == 16'(HEADER_BYTES));
            fin        = res_last;
            adv        = 1'b1;
            phase_nxt  = ph_e;
          end
        end
      end else begin
        tb_v     = 1'b1;
        tb_kind  = K_ARG;
        res_arg  = in_data_byte;
        res_last = (k1 == {1'b0, size});
        fin      = (k1 >= {1'b0, size});
      end
      if (adv) begin
        pos_nxt = REGION_BITS'(pos1_s);
        if (fin) begin
          k_nxt = '0;
          if (pos1_s >= end_s) phase_nxt = PH_PENDING;
        end else begin
          k_nxt = k1[15:0];
        end
      end
    end

    if (pend) begin
      res_opcode = '0;
      res_size   = '0;
      res_time   = '0;
      res_flags  = '0;
      res_arg    = '0;
      res_last   = 1'b0;
      if (tb_v) phase_nxt = PH_PENDING;
    end else begin
      res_v    = tb_v;
      res_kind = tb_kind;
      if (tb_kind != K_HEADER && tb_kind != K_ARG) begin
        res_last = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_op_r   <= 16'hFFFF;
      term_size_r <= '0;
      max_op_r    <= 15'd127;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TERM_OP:   term_op_r   <= cfg_wdata;
        CFG_TERM_SIZE: term_size_r <= cfg_wdata;
        CFG_MAX_OP:    max_op_r    <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pos_r       <= '0;
      end_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        pos_r       <= pos_nxt;
        end_r       <= end_nxt;
        k_r         <= k_nxt;
        out_valid_r <= res_v;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_r <= hold_nxt;
      for (int i = 0; i < 4; i++) hw_r[i] <= hw_nxt[i];
      if (res_v) begin
        kind_r     <= res_kind;
        opcode_r   <= res_opcode;
        size_out_r <= res_size;
        time_r     <= res_time;
        flags_r    <= res_flags;
        arg_r      <= res_arg;
        last_r     <= res_last;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_opcode        = opcode_r;
  assign out_byte_size     = size_out_r;
  assign out_time_value    = time_r;
  assign out_operand_flags = flags_r;
  assign out_arg_byte      = arg_r;
  assign out_is_last       = last_r;

  a_term_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TERM |-> (k_r == 16'd2 || k_r == 16'd3))
    else $error("terminator phase with bad instruction position");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PARSE || phase_r == PH_TERM) |-> pos_r <= end_r)
    else $error("region position past end bound");

  a_instr_in_region: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PARSE |-> SW'(k_r) <= SW'(pos_r))
    else $error("instruction position ahead of region position");

  a_header_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == K_HEADER |->
      out_byte_size >= 16'(HEADER_BYTES) && out_byte_size[1:0] == 2'b00)
    else $error("header item with illegal size");

  a_last_only_records: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r != K_HEADER && kind_r != K_ARG |-> !out_is_last)
    else $error("last flag on a status item");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the animation script stream parser top level.
`timescale 1ns / 1ps

module testbench;
  import assp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    kind_t       kind;
    logic [14:0] opcode;
    logic [15:0] byte_size;
    logic [15:0] time_value;
    logic [15:0] flags;
    logic [7:0]  arg;
    logic        last;
  } parse_rec_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_data_byte;
  logic               in_region_start;
  logic [23:0]        in_region_length;
  logic               out_valid;
  logic               out_ready;
  kind_t              out_kind;
  logic [14:0]        out_opcode;
  logic [15:0]        out_byte_size;
  logic signed [15:0] out_time_value;
  logic [15:0]        out_operand_flags;
  logic [7:0]         out_arg_byte;
  logic               out_is_last;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_wdata;

  anim_script_stream_parser_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_region_start   (in_region_start),
    .in_region_length  (in_region_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_opcode        (out_opcode),
    .out_byte_size     (out_byte_size),
    .out_time_value    (out_time_value),
    .out_operand_flags (out_operand_flags),
    .out_arg_byte      (out_arg_byte),
    .out_is_last       (out_is_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // parser state mirror
  logic [23:0] p_pos;
  logic [23:0] p_end;
  logic [15:0] p_ipos;
  logic [15:0] p_words [4];
  logic [7:0]  p_low;
  phase_t      p_phase;

  // register mirror
  logic [15:0] c_term_op;
  logic [15:0] c_term_size;
  logic [14:0] c_max_op;

  parse_rec_t records_due [$];
  int         mismatches;
  int         items_sent;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL anim_script_stream_parser_top");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic void expect_rec(input parse_rec_t r);
    records_due.insert(records_due.size(), r);
  endfunction

  // one byte of an open instruction; returns 1 when a record comes out
  function automatic bit advance_byte(input logic [7:0] b, output parse_rec_t r);
    longint    pos;
    longint    k;
    longint    start;
    longint    size;
    logic [15:0] w;
    bit        got;
    bit        finish;
    pos    = p_pos;
    k      = p_ipos;
    start  = pos - k;
    w      = {b, p_low};
    got    = 1'b0;
    finish = 1'b0;
    r      = '0;
    if (p_phase == PH_TERM) begin
      if (k == 2) begin
        p_low  = b;
        p_ipos = 16'd3;
        p_pos  = 24'(pos + 1);
        return 1'b0;
      end
      r.kind  = (w == c_term_size) ? K_END_OK : K_BAD_TERM_SIZE;
      p_phase = PH_DONE;
      return 1'b1;
    end
    if (k == 0) begin
      if (start + 2 > p_end) begin
        r.kind  = K_NO_TERM;
        p_phase = PH_DONE;
        return 1'b1;
      end
      p_low = b;
    end else if (k < HEADER_BYTES) begin
      if (k % 2 == 0) p_low = b;
      else p_words[(k >> 1) & 3] = w;
      if (k == 1) begin
        if (w[15]) begin
          if (w != c_term_op) begin
            r.kind  = K_BAD_TERM_OP;
            p_phase = PH_DONE;
          end else if (start + 4 <= p_end) begin
            p_phase = PH_TERM;
            p_ipos  = 16'd2;
            p_pos   = 24'(pos + 1);
            return 1'b0;
          end else begin
            r.kind  = K_END_OK;
            p_phase = PH_DONE;
          end
          return 1'b1;
        end
        if (start + HEADER_BYTES > p_end) begin
          r.kind  = K_HDR_PAST_BOUND;
          p_phase = PH_DONE;
          return 1'b1;
        end
      end else if (k == HEADER_BYTES - 1) begin
        size = p_words[1];
        if (size < HEADER_BYTES || size % 4 != 0) begin
          r.kind  = K_BAD_SIZE;
          p_phase = PH_DONE;
          return 1'b1;
        end
        if (start + size > p_end) begin
          r.kind  = K_INS_PAST_BOUND;
          p_phase = PH_DONE;
          return 1'b1;
        end
        if (p_words[0][14:0] > c_max_op) begin
          r.kind  = K_OP_TOO_HIGH;
          p_phase = PH_DONE;
          return 1'b1;
        end
        r.kind       = K_HEADER;
        r.opcode     = p_words[0][14:0];
        r.byte_size  = p_words[1];
        r.time_value = p_words[2];
        r.flags      = p_words[3];
        r.last       = (size == HEADER_BYTES);
        got          = 1'b1;
        finish       = (size == HEADER_BYTES);
      end
    end else begin
      size   = p_words[1];
      r.kind = K_ARG;
      r.arg  = b;
      r.last = (k + 1 == size);
      got    = 1'b1;
      finish = (k + 1 >= size);
    end
    p_pos = 24'(pos + 1);
    if (finish) begin
      p_ipos = '0;
      if (pos + 1 >= p_end) p_phase = PH_PENDING;
    end else begin
      p_ipos = 16'(k + 1);
    end
    return got;
  endfunction

  function automatic void track_item(input logic [7:0] b, input logic start,
                                     input logic [23:0] len);
    parse_rec_t r;
    parse_rec_t dropped;
    bit         reported;
    reported = 1'b0;
    if (p_phase == PH_PENDING) begin
      r      = '0;
      r.kind = K_NO_TERM;
      expect_rec(r);
      p_phase  = PH_DONE;
      reported = 1'b1;
    end
    if (start) begin
      p_end   = len;
      p_pos   = '0;
      p_ipos  = '0;
      p_low   = '0;
      p_phase = PH_PARSE;
    end
    if (p_phase != PH_PARSE && p_phase != PH_TERM) return;
    if (!reported) begin
      if (advance_byte(b, r)) expect_rec(r);
    end else if (advance_byte(b, dropped)) begin
      // second no-terminator report waits for the next item
      p_phase = PH_PENDING;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    parse_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (records_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected record, kind %0d", $time, out_kind);
      end else begin
        want = records_due.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("opcode", want.opcode, out_opcode);
        check_field("byte_size", want.byte_size, out_byte_size);
        check_field("time_value", want.time_value, $unsigned(out_time_value));
        check_field("operand_flags", want.flags, out_operand_flags);
        check_field("arg_byte", want.arg, out_arg_byte);
        check_field("is_last", want.last, out_is_last);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start, input logic [23:0] len);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_region_start  <= start;
    in_region_length <= len;
    do @(posedge clk); while (!in_ready);
    track_item(b, start, len);
    items_sent++;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (records_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TERM_OP:   c_term_op   = val;
      CFG_TERM_SIZE: c_term_size = val;
      CFG_MAX_OP:    c_max_op    = val[14:0];
      default: ;
    endcase
  endtask

  task automatic test_idle_bytes();
    send_byte(8'hA5, 1'b0, 24'hFFFFFF);
    send_byte(8'h5A, 1'b0, 24'h000000);
  endtask

  task automatic test_short_regions();
    send_byte(8'h00, 1'b1, 24'd0);    // zero length
    send_byte(8'hFF, 1'b1, 24'd2);    // terminator, no room for size
    send_byte(8'hFF, 1'b0, 24'd0);
    send_byte(8'h00, 1'b1, 24'd4);    // foreign negative opcode
    send_byte(8'h80, 1'b0, 24'd0);
    send_byte(8'h05, 1'b1, 24'd3);    // header over bound
    send_byte(8'h00, 1'b0, 24'd0);
  endtask

  task automatic test_header_then_terminator();
    logic [7:0] hdr [8];
    int i;
    hdr = '{8'h7F, 8'h00, 8'h08, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF};
    for (i = 0; i < 8; i++) send_byte(hdr[i], i == 0, 24'd8);
    // report held over, new region without room, then a clean terminator
    send_byte(8'h00, 1'b1, 24'd1);
    send_byte(8'hFF, 1'b1, 24'd6);
    send_byte(8'hFF, 1'b0, 24'd0);
    send_byte(8'h00, 1'b0, 24'd0);
    send_byte(8'h00, 1'b0, 24'd0);
  endtask

  task automatic run_script();
    logic [7:0]  bytes_q [$];
    logic [14:0] op;
    logic [15:0] tm;
    logic [15:0] fl;
    logic [15:0] tw;
    int mode;
    int n;
    int sz;
    int len;
    int i;
    int j;
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      n = $urandom_range(0, 12);
      for (i = 0; i < n; i++) bytes_q.insert(bytes_q.size(), 8'($urandom));
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                        : $urandom_range(0, n + 2);
    end else begin
      n = $urandom_range(0, 4);
      for (i = 0; i < n; i++) begin
        op = 15'($urandom_range(0, c_max_op));
        case ($urandom_range(0, 19))
          0: op = 15'($urandom_range(0, 15'h7FFF));
          1: op = c_max_op;
          default: ;
        endcase
        sz = 8 + 4 * $urandom_range(0, 3);
        j  = $urandom_range(0, 39);
        if (j == 0) sz = $urandom_range(0, 40);
        else if (j == 1) sz = 8 + 4 * $urandom_range(4, 60);
        tm = 16'($urandom);
        fl = 16'($urandom);
        bytes_q.insert(bytes_q.size(), op[7:0]);
        bytes_q.insert(bytes_q.size(), {1'b0, op[14:8]});
        bytes_q.insert(bytes_q.size(), sz[7:0]);
        bytes_q.insert(bytes_q.size(), sz[15:8]);
        bytes_q.insert(bytes_q.size(), tm[7:0]);
        bytes_q.insert(bytes_q.size(), tm[15:8]);
        bytes_q.insert(bytes_q.size(), fl[7:0]);
        bytes_q.insert(bytes_q.size(), fl[15:8]);
        for (j = 8; j < sz; j++) bytes_q.insert(bytes_q.size(), 8'($urandom));
      end
      if ($urandom_range(0, 99) < 85) begin
        tw = ($urandom_range(0, 19) == 0) ? (16'h8000 | 16'($urandom_range(0, 16'h7FFF)))
                                          : c_term_op;
        bytes_q.insert(bytes_q.size(), tw[7:0]);
        bytes_q.insert(bytes_q.size(), tw[15:8]);
        if ($urandom_range(0, 99) < 80) begin
          tw = ($urandom_range(0, 9) == 0) ? 16'($urandom) : c_term_size;
          bytes_q.insert(bytes_q.size(), tw[7:0]);
          bytes_q.insert(bytes_q.size(), tw[15:8]);
        end
      end
      n = $urandom_range(0, 2);
      for (i = 0; i < n; i++) bytes_q.insert(bytes_q.size(), 8'($urandom));
      len = bytes_q.size();
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          len = len - $urandom_range(1, 4);
          if (len < 0) len = 0;
        end
        3, 4, 5: len = len + $urandom_range(1, 4);
        default: ;
      endcase
    end
    for (i = 0; i < bytes_q.size(); i++)
      send_byte(bytes_q[i], i == 0 || $urandom_range(0, 99) == 0,
                i == 0 ? 24'(len) : 24'($urandom_range(0, 24'hFFFFFF)));
  endtask

  task automatic test_scripts(input int idle_pct, input int stall_pct, input int quota,
                              input logic [15:0] term_op, input logic [15:0] term_size,
                              input logic [15:0] max_op);
    int target;
    drain();
    write_reg(CFG_TERM_OP, term_op);
    write_reg(CFG_TERM_SIZE, term_size);
    write_reg(CFG_MAX_OP, max_op);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = items_sent + quota;
    while (items_sent < target) run_script();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data_byte     = '0;
    in_region_start  = 1'b0;
    in_region_length = '0;
    out_ready        = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    mismatches       = 0;
    items_sent       = 0;
    cycle_count      = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    c_term_op        = 16'hFFFF;
    c_term_size      = 16'h0000;
    c_max_op         = 15'd127;
    p_pos            = '0;
    p_end            = '0;
    p_ipos           = '0;
    p_words          = '{default: '0};
    p_low            = '0;
    p_phase          = PH_IDLE;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_bytes();
    test_short_regions();
    test_header_then_terminator();
    test_scripts(0, 0, 400, 16'h8000, 16'hFFFF, 16'h7FFF);
    test_scripts(82, 0, 400, 16'hFFFF, 16'h0000, 16'h0000);
    test_scripts(0, 82, 400, 16'h8000 | 16'($urandom_range(0, 16'h7FFF)),
                 16'($urandom), 16'($urandom_range(0, 300)));
    test_scripts(19, 19, 400, 16'h8000 | 16'($urandom_range(0, 16'h7FFF)),
                 16'($urandom), 16'($urandom_range(0, 15'h7FFF)));

    drain();
    repeat (10) @(posedge clk);
    if (records_due.size() != 0) begin
      $display("%0t: %0d expected records never arrived", $time, records_due.size());
      mismatches += records_due.size();
    end
    if (mismatches == 0) begin
      $display("PASS anim_script_stream_parser_top");
    end else begin
      $display("FAIL anim_script_stream_parser_top");
    end
    $finish;
  end

endmodule
